// ----- design/ssk_pkg.sv -----
// Shared types and constants for the stable descending key/payload sorter.
// No dependencies; imported by ssk_cell and stable_sort_key_payload_desc_unit.
package ssk_pkg;

    // Capacity of the sort chain, one cell per stored pair
    localparam int MAX_ITEMS = 64;
    // Fill counter width, able to hold MAX_ITEMS itself
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 32;
    localparam int DATA_W    = KEY_W + PAY_W;

    // One key/payload pair
    typedef struct packed {
        logic [PAY_W-1:0] payload;
        logic [KEY_W-1:0] key;
    } t_pair;

    // Contents of one cell of the chain
    typedef struct packed {
        logic  valid;
        t_pair pair;
    } t_slot;

    // Per-cycle command broadcast along the chain
    typedef struct packed {
        logic insert;   // place the broadcast pair into the sorted row
        logic shift;    // move every slot one place towards cell 0
    } t_cell_ctrl;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

endpackage

// ----- design/ssk_cell.sv -----
// One cell of the systolic insertion chain: holds a single key/payload pair.
// Depends on ssk_pkg for the slot, pair and control types.
module ssk_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssk_pkg::t_cell_ctrl i_ctrl,
    input  ssk_pkg::t_pair      i_new,
    input  logic                i_prev_ins,
    input  ssk_pkg::t_slot      i_prev,
    input  ssk_pkg::t_slot      i_next,
    output logic                o_ins,
    output ssk_pkg::t_slot      o_slot
);
    import ssk_pkg::*;

    logic  r_valid;
    t_pair r_pair;
    t_slot n_slot;

    // Insert point: empty slot, or stored key strictly below the new one,
    // so equal keys keep arrival order
    assign o_ins = !r_valid || ($signed(r_pair.key) < $signed(i_new.key));

    // Next contents: drain left, take the new pair, or shift right behind it
    always_comb begin
        n_slot.valid = r_valid;
        n_slot.pair  = r_pair;
        if (i_ctrl.shift) begin
            n_slot = i_next;
        end else if (i_ctrl.insert && o_ins) begin
            if (i_prev_ins) begin
                n_slot = i_prev;
            end else begin
                n_slot.valid = 1'b1;
                n_slot.pair  = i_new;
            end
        end
    end

    // Occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
        end
    end

    // Pair storage, no reset needed
    always_ff @(posedge i_clk) begin
        r_pair <= n_slot.pair;
    end

    assign o_slot.valid = r_valid;
    assign o_slot.pair  = r_pair;

endmodule

// ----- design/stable_sort_key_payload_desc_unit.sv -----
// Top level of the stable descending key/payload sorter.
// Depends on ssk_pkg and instantiates a row of ssk_cell.
//
// Usage:
//   Slave channel s_axis_tdata carries one pair per transaction: key in the low
//   32 bits, payload above it; s_axis_tlast closes the set. Up to MAX_ITEMS pairs
//   are kept; further pairs of the set are dropped and flagged as overflow.
//   Each accepted pair is inserted into the chain of cells as it is taken, so
//   loading runs at one pair per cycle.
//   Once the closing transaction is accepted, the chain drains through the
//   master channel, largest key first, ties in arrival order: n results at
//   one per cycle unless the master stalls, the first valid in the cycle after
//   the closing pair. m_axis_tlast marks the final result, m_axis_tuser the
//   overflow flag of the set. While draining, s_axis_tready is low; the next set
//   starts loading in the cycle after the final result is taken.
//   A stall on the master side holds the chain and the current result.
//   Reset empties the chain and clears the count and the overflow flag.
module stable_sort_key_payload_desc_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [ssk_pkg::DATA_W-1:0] s_axis_tdata,  // key[31:0], payload[63:32]
    input  logic                       s_axis_tlast,  // last_item
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [ssk_pkg::DATA_W-1:0] m_axis_tdata,  // sorted_key[31:0], sorted_payload[63:32]
    output logic                       m_axis_tlast,  // last_result
    output logic [0:0]                 m_axis_tuser   // overflow
);
    import ssk_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;

    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_full;
    t_cell_ctrl       w_ctrl;
    t_pair            w_new;
    t_slot            w_slot [MAX_ITEMS];
    logic             w_ins  [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] w_valid;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign w_full    = (r_count == CNT_W'(MAX_ITEMS));

    assign w_new.key     = s_axis_tdata[KEY_W-1:0];
    assign w_new.payload = s_axis_tdata[DATA_W-1:KEY_W];

    assign w_ctrl.insert = w_in_acc && !w_full;
    assign w_ctrl.shift  = w_out_acc;

    // Chain of cells; each sees its left neighbour for insertion and its
    // right neighbour for draining
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        t_slot w_prev;
        logic  w_prev_ins;
        t_slot w_next;

        if (g == 0) begin : g_head
            assign w_prev     = '0;
            assign w_prev_ins = 1'b0;
        end else begin : g_body
            assign w_prev     = w_slot[g-1];
            assign w_prev_ins = w_ins[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_slot[g+1];
        end

        ssk_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_new      (w_new),
            .i_prev_ins (w_prev_ins),
            .i_prev     (w_prev),
            .i_next     (w_next),
            .o_ins      (w_ins[g]),
            .o_slot     (w_slot[g])
        );

        assign w_valid[g] = w_slot[g].valid;
    end

    // Handshake and result from the head cell
    assign s_axis_tready   = (r_state == ST_LOAD);
    assign m_axis_tvalid   = (r_state == ST_DRAIN) && w_slot[0].valid;
    assign m_axis_tdata    = {w_slot[0].pair.payload, w_slot[0].pair.key};
    assign m_axis_tlast    = w_slot[0].valid && !w_slot[1].valid;
    assign m_axis_tuser[0] = r_ovf;

    // Next state, fill count and overflow flag
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (s_axis_tlast) begin
                        n_state = ST_DRAIN;
                        n_count = '0;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_out_acc && m_axis_tlast) begin
                    n_state = ST_LOAD;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

`ifndef SYNTH
    // Occupied cells always form a contiguous run from cell 0
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + MAX_ITEMS'(1))) == '0)
        else $error("sort chain has a gap in its occupied cells");

    // Fill count matches the number of occupied cells while loading
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> ($countones(w_valid) == int'(r_count)))
        else $error("fill count disagrees with chain occupancy");

    // A closing transaction always starts a non-empty drain
    a_close_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tlast) |=> (r_state == ST_DRAIN && w_slot[0].valid))
        else $error("closing transaction did not start a drain");

    // Results are sorted: head key never below the next one during drain
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && w_slot[1].valid) |->
            !($signed(w_slot[0].pair.key) < $signed(w_slot[1].pair.key)))
        else $error("drain order is not descending");
`endif

endmodule
